/* rtl/perfect_number_test_macros.svh */
// Assertion macros used by the checker file of the perfect number test.
`ifndef PERFECT_NUMBER_TEST_MACROS_SVH
`define PERFECT_NUMBER_TEST_MACROS_SVH

// Same-cycle implication, sampled on the rising clock edge, off during reset.
`define PNT_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on the rising clock edge, off during reset.
`define PNT_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* rtl/pnt_pkg.sv */
package pnt_pkg;

    // Default width of the number under test.
    localparam int PNT_WIDTH_DEF = 16;

endpackage

/* rtl/perfect_number_test.sv */
// Perfect number test. Pulse start while busy is low to hand in one item; the
// result comes back on o_perfect for exactly one cycle, flagged by o_strobe, and
// must be taken in that cycle because the block cannot be stalled. Odd numbers
// and numbers below two answer in the cycle after start without going busy.
// Even numbers search divisor pairs (d, n/d) for d from 2 while d <= n/d on one
// shared bit-serial divider; for each candidate the divider runs, its result is
// evaluated, and when d divides n the sum takes d and then n/d (once if equal).
// The search stops as soon as the running divisor sum exceeds n, or when no pair
// is left. Busy stays high for the whole search.
module perfect_number_test
    import pnt_pkg::*;
#(
    parameter int WIDTH = PNT_WIDTH_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             start,
    output logic             busy,
    input  logic [WIDTH-1:0] i_number,
    output logic             o_perfect,
    output logic             o_strobe
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_DIV  = 5'b00010,
        S_EVAL = 5'b00100,
        S_ADDQ = 5'b01000,
        S_CHK  = 5'b10000
    } t_state;

    t_state           r_state, n_state;
    logic [WIDTH-1:0] r_n, n_n;
    logic [WIDTH-1:0] r_d, n_d;
    logic [WIDTH:0]   r_sum, n_sum;
    logic             r_perfect, n_perfect;
    logic             r_strobe, n_strobe;
    logic             r_div_go, n_div_go;

    logic             div_done;
    logic [WIDTH-1:0] div_quo;
    logic [WIDTH-1:0] div_rem;
    logic             sum_over;

    // Shared divider: n / d and n % d for the current candidate.
    pnt_divider #(
        .WIDTH (WIDTH)
    ) u_divider (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (r_div_go),
        .i_dividend  (r_n),
        .i_divisor   (r_d),
        .o_done      (div_done),
        .o_quotient  (div_quo),
        .o_remainder (div_rem)
    );

    assign sum_over = r_sum > {1'b0, r_n};

    // Sequencer over candidates; each state does at most one add.
    always_comb begin
        n_state   = r_state;
        n_n       = r_n;
        n_d       = r_d;
        n_sum     = r_sum;
        n_perfect = r_perfect;
        n_strobe  = 1'b0;
        n_div_go  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (start) begin
                    n_n = i_number;
                    if (!i_number[0] && (i_number[WIDTH-1:1] != '0)) begin
                        n_sum    = (WIDTH + 1)'(1);
                        n_d      = WIDTH'(2);
                        n_div_go = 1'b1;
                        n_state  = S_DIV;
                    end else begin
                        n_perfect = 1'b0;
                        n_strobe  = 1'b1;
                    end
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_EVAL;
                end
            end
            S_EVAL: begin
                if (div_quo < r_d) begin
                    // No pair left: the sum is final.
                    n_perfect = (r_sum == {1'b0, r_n});
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                end else if (div_rem == '0) begin
                    n_sum   = r_sum + {1'b0, r_d};
                    n_state = S_ADDQ;
                end else begin
                    n_d      = r_d + WIDTH'(1);
                    n_div_go = 1'b1;
                    n_state  = S_DIV;
                end
            end
            S_ADDQ: begin
                if (sum_over) begin
                    n_perfect = 1'b0;
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    if (div_quo != r_d) begin
                        n_sum = r_sum + {1'b0, div_quo};
                    end
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if (sum_over) begin
                    n_perfect = 1'b0;
                    n_strobe  = 1'b1;
                    n_state   = S_IDLE;
                end else begin
                    n_d      = r_d + WIDTH'(1);
                    n_div_go = 1'b1;
                    n_state  = S_DIV;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Control registers reset; the datapath registers do not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_strobe <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_strobe <= n_strobe;
            r_div_go <= n_div_go;
        end
        r_n       <= n_n;
        r_d       <= n_d;
        r_sum     <= n_sum;
        r_perfect <= n_perfect;
    end

    assign busy      = (r_state != S_IDLE);
    assign o_perfect = r_perfect;
    assign o_strobe  = r_strobe;

endmodule

/* rtl/pnt_divider.sv */
module pnt_divider #(
    parameter int WIDTH = 16
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [WIDTH-1:0] i_dividend,
    input  logic [WIDTH-1:0] i_divisor,
    output logic             o_done,
    output logic [WIDTH-1:0] o_quotient,
    output logic [WIDTH-1:0] o_remainder
);

    localparam int CW = $clog2(WIDTH);

    logic             r_busy, n_busy;
    logic             r_done, n_done;
    logic [CW-1:0]    r_cnt, n_cnt;
    logic [WIDTH-1:0] r_quo, n_quo;
    logic [WIDTH-1:0] r_rem, n_rem;
    logic [WIDTH-1:0] r_dsr, n_dsr;
    logic [WIDTH:0]   shifted;
    logic [WIDTH:0]   diff;

    // One restoring step: shift in the next dividend bit and try a subtract.
    assign shifted = {r_rem, r_quo[WIDTH-1]};
    assign diff    = shifted - {1'b0, r_dsr};

    always_comb begin
        n_busy = r_busy;
        n_done = 1'b0;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_dsr  = r_dsr;
        if (i_start) begin
            n_busy = 1'b1;
            n_cnt  = CW'(WIDTH - 1);
            n_quo  = i_dividend;
            n_rem  = '0;
            n_dsr  = i_divisor;
        end else if (r_busy) begin
            if (!diff[WIDTH]) begin
                n_rem = diff[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b1};
            end else begin
                n_rem = shifted[WIDTH-1:0];
                n_quo = {r_quo[WIDTH-2:0], 1'b0};
            end
            if (r_cnt == '0) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end else begin
                n_cnt = r_cnt - CW'(1);
            end
        end
    end

    // Control state is reset; the datapath registers are not.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
            r_cnt  <= n_cnt;
        end
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_dsr <= n_dsr;
    end

    assign o_done      = r_done;
    assign o_quotient  = r_quo;
    assign o_remainder = r_rem;

endmodule

/* rtl/pnt_checker.sv */
`include "perfect_number_test_macros.svh"

module pnt_checker #(
    parameter int WIDTH = 16
) (
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             start,
    input logic             busy,
    input logic [WIDTH-1:0] i_number,
    input logic             o_perfect,
    input logic             o_strobe
);

    // A result is only ever shown while the block is free again.
    `PNT_ASSERT_NOW(a_strobe_idle, o_strobe, !busy, "result shown while busy")

    // An odd number answers not perfect in the next cycle.
    `PNT_ASSERT_NEXT(a_odd_fast, start && !busy && i_number[0], o_strobe && !o_perfect && !busy, "odd item not rejected at once")

    // An even number of two or more starts a search and gives no result yet.
    `PNT_ASSERT_NEXT(a_even_search, start && !busy && !i_number[0] && (i_number[WIDTH-1:1] != '0), busy && !o_strobe, "even item did not start a search")

    // The end of a search always delivers its result.
    `PNT_ASSERT_NOW(a_end_result, $fell(busy), o_strobe, "search ended without a result")

endmodule

bind perfect_number_test pnt_checker #(
    .WIDTH (WIDTH)
) u_pnt_checker (
    .i_clk     (i_clk),
    .i_rst_n   (i_rst_n),
    .start     (start),
    .busy      (busy),
    .i_number  (i_number),
    .o_perfect (o_perfect),
    .o_strobe  (o_strobe)
);

/* bench/tb_perfect_number_test.sv */
`timescale 1ns / 100ps

module tb_perfect_number_test;
    import pnt_pkg::*;

    localparam int WIDTH = PNT_WIDTH_DEF;

    // Worst-case search time per candidate, in cycles.
    localparam int CANDIDATE_CYCLES = WIDTH + 5;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             start = 1'b0;
    logic [WIDTH-1:0] i_number = '0;
    logic             busy;
    logic             o_perfect;
    logic             o_strobe;

    // Verdicts still owed by the block, oldest first.
    logic             pending_verdicts[$];
    int               error_count = 0;

    // The only perfect numbers that fit in 16 bits.
    logic [WIDTH-1:0] perfect_values[4] = '{16'd6, 16'd28, 16'd496, 16'd8128};

    perfect_number_test #(
        .WIDTH(WIDTH)
    ) u_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .start    (start),
        .busy     (busy),
        .i_number (i_number),
        .o_perfect(o_perfect),
        .o_strobe (o_strobe)
    );

    // Free-running clock with an 8 ns period.
    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Sums proper divisors in pairs and stops once the sum passes the number.
    function automatic logic predict_perfect(input logic [WIDTH-1:0] value);
        longint unsigned n;
        longint unsigned divisor_sum;
        longint unsigned d;
        n = value;
        if (n < 2 || (n % 2) != 0) begin
            return 1'b0;
        end
        divisor_sum = 1;
        for (d = 2; d * d <= n; d++) begin
            if (n % d == 0) begin
                divisor_sum += d;
                if (n / d != d) begin
                    divisor_sum += n / d;
                end
                if (divisor_sum > n) begin
                    return 1'b0;
                end
            end
        end
        return divisor_sum == n;
    endfunction

    task automatic report_mismatch(input string what, input logic want, input logic got);
        error_count++;
        $display("%0t ns: %s: expected perfect=%0b, got %0b", $time, what, want, got);
    endtask

    // Hands one item to the block, optionally after an idle stretch, and
    // records its verdict once the block has taken it.
    task automatic send_number(input logic [WIDTH-1:0] value, input int gap_pct);
        bit taken;
        if ($urandom_range(99) < gap_pct) begin
            repeat ($urandom_range(1, 40)) begin
                @(negedge i_clk);
                start    <= 1'b0;
                i_number <= WIDTH'($urandom);
            end
        end
        @(negedge i_clk);
        start    <= 1'b1;
        i_number <= value;
        taken = 1'b0;
        while (!taken) begin
            @(posedge i_clk);
            if (!busy) begin
                taken = 1'b1;
            end
        end
        pending_verdicts.push_back(predict_perfect(value));
    endtask

    // Drops start, waits for every verdict, then keeps idling so that a stray
    // result would still show up.
    task automatic wait_drained();
        @(negedge i_clk);
        start <= 1'b0;
        while (pending_verdicts.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (2 * CANDIDATE_CYCLES) @(posedge i_clk);
    endtask

    // Mostly even numbers so the divisor search runs, with perfect numbers
    // mixed in so true verdicts are frequent, and some odd noise.
    function automatic logic [WIDTH-1:0] pick_number();
        int roll;
        roll = $urandom_range(99);
        if (roll < 15) begin
            return perfect_values[$urandom_range(3)];
        end else if (roll < 25) begin
            return WIDTH'($urandom) | WIDTH'(1);
        end else if (roll < 35) begin
            return WIDTH'(2 * $urandom_range(1, 100));
        end else if (roll < 40) begin
            return WIDTH'(1) << $urandom_range(1, WIDTH - 1);
        end
        return WIDTH'($urandom) & ~WIDTH'(1);
    endfunction

    // Zero, one and odd numbers are answered at once.
    task automatic test_trivial_inputs();
        send_number(16'd0, 0);
        send_number(16'd1, 0);
        send_number(16'd3, 0);
        send_number(16'd8127, 0);
        send_number(16'd8129, 0);
        send_number(16'hFFFF, 0);
        send_number(16'h5555, 0);
        wait_drained();
    endtask

    // Every perfect number in range, back to back.
    task automatic test_known_perfect();
        foreach (perfect_values[i]) begin
            send_number(perfect_values[i], 0);
        end
        wait_drained();
    endtask

    // Even numbers: smallest, abundant ones that stop early, and deficient
    // ones that search all the way to the square root.
    task automatic test_even_edges();
        send_number(16'd2, 0);
        send_number(16'd4, 0);
        send_number(16'd12, 0);
        send_number(16'd8130, 0);
        send_number(16'h8000, 0);
        send_number(16'hFFFE, 0);
        send_number(16'hFFFC, 0);
        send_number(16'hAAAA, 0);
        wait_drained();
    endtask

    task automatic test_random_numbers(input int count, input int gap_pct);
        repeat (count) begin
            send_number(pick_number(), gap_pct);
        end
        wait_drained();
    endtask

    // Every strobe is matched against the oldest pending verdict.
    always @(posedge i_clk) begin : check_verdicts
        logic want;
        if (i_rst_n && o_strobe) begin
            if (pending_verdicts.size() == 0) begin
                report_mismatch("result with no item pending", 1'bx, o_perfect);
            end else begin
                want = pending_verdicts.pop_front();
                if (o_perfect !== want) begin
                    report_mismatch("wrong verdict", want, o_perfect);
                end
            end
        end
    end

    initial begin
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        test_trivial_inputs();
        test_known_perfect();
        test_even_edges();
        test_random_numbers(27, 0);
        test_random_numbers(27, 49);
        test_random_numbers(27, 32);
        if (error_count == 0) begin
            $display("tb_perfect_number_test: clean");
        end else begin
            $display("tb_perfect_number_test: errors");
        end
        $finish;
    end

    // About 100 items at up to 256 candidates each, gaps included, finish well
    // inside this limit.
    initial begin
        #30ms;
        $display("tb_perfect_number_test: errors");
        $finish;
    end

endmodule
